// ===== rtl/bsmt_pkg.sv =====
// Package for the seen-message tracker: payload types, sequencer states,
// hash command bundle and fixed constants. No dependencies.
package bsmt_pkg;

  localparam int unsigned FILTER_BITS_LOG2 = 19;
  localparam int unsigned NUM_PROBES       = 8;

  localparam int unsigned PAGE_W    = 16;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned PAGE_SHIFT = 5;
  localparam int unsigned ADDR_SHIFT = 11;
  localparam logic [31:0] KNUTH_MULT = 32'd2654435761;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_UNSEEN    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_UNSEEN = 1'd1;

  typedef enum logic [0:0] {
    FUNC_MESSAGE  = 1'b0,
    FUNC_ACTIVATE = 1'b1
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] addr;
    logic              activate_value;
  } bsmt_in_t;

  typedef struct packed {
    logic unseen;
    logic skip_enabled;
    logic skip_activated;
    logic menu_changed;
    logic filter_dirty;
  } bsmt_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_PAGE,
    ST_MUL_ADDR,
    ST_LOAD_H2,
    ST_PROBE_RD,
    ST_PROBE_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic sel_addr;
    logic take_h1;
    logic take_h2;
    logic step;
  } hash_cmd_t;

endpackage

// ===== rtl/bloom_seen_message_tracker.sv =====
// Top level of the seen-message tracker: sequencer, skip state, config and
// output register around bsmt_hash and one bsmt_ram. Depends on bsmt_pkg.
//
//   Channel  Dir  Handshake                 Payload
//   in       in   in_valid_i / in_stall_o    bsmt_in_t
//   out      out  out_valid_o / out_stall_i  bsmt_out_t
//   cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_wdata_i
//
// A message passes from accept to the next accept through two multiplier
// passes, one load of h2, and a read and a write of the filter RAM for every
// probe. An activate request goes from accept straight to the result state.
// After reset a clearing pass writes all 2^(FilterBitsLog2-3) filter bytes,
// one per cycle, while in_stall_o stays high; config writes are always taken.
// A finished result waits in the output register while out_stall_i is high;
// the next item is accepted meanwhile and its result holds until it drains.
module bloom_seen_message_tracker #(
  parameter int unsigned FilterBitsLog2 = bsmt_pkg::FILTER_BITS_LOG2,
  parameter int unsigned NumProbes      = bsmt_pkg::NUM_PROBES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bsmt_pkg::bsmt_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bsmt_pkg::bsmt_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bsmt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                           cfg_wdata_i
);
  import bsmt_pkg::*;

  localparam int unsigned ByteAddrW = FilterBitsLog2 - 3;
  localparam int unsigned Depth     = 2 ** ByteAddrW;
  localparam int unsigned CntW      = (NumProbes > 1) ? $clog2(NumProbes) : 1;
  localparam logic [CntW-1:0] LastProbe = CntW'(NumProbes - 1);

  state_e                    state_q, state_d;
  logic [ByteAddrW-1:0]      clr_q, clr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  bsmt_in_t                  item_q, item_d;
  logic                      unseen_q, unseen_d;
  logic                      en_q, en_d;
  logic                      act_q, act_d;
  logic                      dirty_q, dirty_d;
  logic                      skip_q, skip_d;
  logic                      stop_q, stop_d;
  logic                      out_valid_q, out_valid_d;
  bsmt_out_t                 out_q, out_d;

  hash_cmd_t                 cmd;
  logic [FilterBitsLog2-1:0] probe;
  logic [7:0]                bit_mask;
  logic                      ram_we;
  logic [ByteAddrW-1:0]      ram_waddr;
  logic [7:0]                ram_wdata;
  logic [7:0]                ram_rdata;
  logic                      accept;
  logic                      out_load;
  logic                      slot_free;
  logic                      bit_clear;

  bsmt_hash #(
    .FilterBitsLog2(FilterBitsLog2)
  ) u_hash (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .page_i (item_q.page),
    .addr_i (item_q.addr),
    .probe_o(probe)
  );

  bsmt_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_filter (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(probe[FilterBitsLog2-1:3]),
    .rdata_o(ram_rdata)
  );

  assign bit_mask    = 8'b1 << probe[2:0];
  assign bit_clear   = (ram_rdata & bit_mask) == 8'h00;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.func == FUNC_ACTIVATE) ? ST_DONE : ST_MUL_PAGE;
        end
      end
      ST_MUL_PAGE: state_d = ST_MUL_ADDR;
      ST_MUL_ADDR: state_d = ST_LOAD_H2;
      ST_LOAD_H2:  state_d = ST_PROBE_RD;
      ST_PROBE_RD: state_d = ST_PROBE_WR;
      ST_PROBE_WR: begin
        state_d = (cnt_q == LastProbe) ? ST_DONE : ST_PROBE_RD;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    cmd        = '0;
    ram_we     = 1'b0;
    ram_waddr  = probe[FilterBitsLog2-1:3];
    ram_wdata  = ram_rdata | bit_mask;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'h00;
      end
      ST_IDLE: in_stall_o = 1'b0;
      ST_MUL_PAGE: cmd.mul_en = 1'b1;
      ST_MUL_ADDR: begin
        cmd.mul_en   = 1'b1;
        cmd.sel_addr = 1'b1;
        cmd.take_h1  = 1'b1;
      end
      ST_LOAD_H2: cmd.take_h2 = 1'b1;
      ST_PROBE_RD: ;
      ST_PROBE_WR: begin
        ram_we   = 1'b1;
        cmd.step = 1'b1;
      end
      ST_DONE: out_load = slot_free;
      default: ;
    endcase
  end

  // datapath and skip state
  always_comb begin
    clr_d       = (state_q == ST_CLEAR) ? clr_q + 1'b1 : clr_q;
    item_d      = accept ? in_data_i : item_q;
    cnt_d       = cnt_q;
    unseen_d    = unseen_q;
    en_d        = en_q;
    act_d       = act_q;
    dirty_d     = dirty_q;
    skip_d      = skip_q;
    stop_d      = stop_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (accept) begin
      cnt_d    = '0;
      unseen_d = 1'b0;
    end
    if (state_q == ST_PROBE_WR) begin
      if (bit_clear) begin
        unseen_d = 1'b1;
      end
      if (cnt_q != LastProbe) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    if (out_load) begin
      if (item_q.func == FUNC_ACTIVATE) begin
        act_d = item_q.activate_value;
      end else begin
        dirty_d = dirty_q || unseen_q;
        if (unseen_q && !skip_q) begin
          en_d = 1'b0;
          if (stop_q) begin
            act_d = 1'b0;
          end
        end else begin
          en_d = 1'b1;
        end
      end
      out_d.unseen         = (item_q.func == FUNC_MESSAGE) && unseen_q;
      out_d.skip_enabled   = en_d;
      out_d.skip_activated = act_d;
      out_d.menu_changed   = (en_d != en_q) || (act_d != act_q);
      out_d.filter_dirty   = dirty_d;
      out_valid_d          = 1'b1;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SKIP_UNSEEN:    skip_d = cfg_wdata_i;
        CFG_STOP_ON_UNSEEN: stop_d = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      unseen_q    <= 1'b0;
      en_q        <= 1'b1;
      act_q       <= 1'b0;
      dirty_q     <= 1'b0;
      skip_q      <= 1'b0;
      stop_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      unseen_q    <= unseen_d;
      en_q        <= en_d;
      act_q       <= act_d;
      dirty_q     <= dirty_d;
      skip_q      <= skip_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |=> dirty_q)
    else $error("filter dirty flag fell");

  a_unseen_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.unseen |-> out_data_o.filter_dirty)
    else $error("unseen result without dirty filter");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> in_stall_o && ram_we)
    else $error("item taken or RAM idle during clearing pass");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastProbe)
    else $error("probe counter out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("result overwrote a stalled transaction");

endmodule

// ===== rtl/bsmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module bsmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/bsmt_hash.sv =====
// Shared hash unit: one 16x32 multiplier for both Knuth hashes and one adder
// that walks the probe positions. Depends on bsmt_pkg.
module bsmt_hash #(
  parameter int unsigned FilterBitsLog2 = bsmt_pkg::FILTER_BITS_LOG2
) (
  input  logic                        clk_i,
  input  bsmt_pkg::hash_cmd_t         cmd_i,
  input  logic [bsmt_pkg::PAGE_W-1:0] page_i,
  input  logic [bsmt_pkg::ADDR_W-1:0] addr_i,
  output logic [FilterBitsLog2-1:0]   probe_o
);
  import bsmt_pkg::*;

  logic [PAGE_W-1:0]         operand;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [FilterBitsLog2-1:0] probe_q, probe_d;
  logic [FilterBitsLog2-1:0] h2_q, h2_d;

  always_comb begin
    operand = cmd_i.sel_addr ? PAGE_W'(addr_i) : page_i;
    prod_d  = cmd_i.mul_en ? PROD_W'(operand) * PROD_W'(KNUTH_MULT) : prod_q;
    h2_d    = cmd_i.take_h2 ? prod_q[ADDR_SHIFT +: FilterBitsLog2] : h2_q;
    probe_d = probe_q;
    if (cmd_i.take_h1) begin
      probe_d = prod_q[PAGE_SHIFT +: FilterBitsLog2];
    end else if (cmd_i.step) begin
      probe_d = probe_q + h2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    h2_q    <= h2_d;
    probe_q <= probe_d;
  end

  assign probe_o = probe_q;

endmodule

// ===== tb/tb_bloom_seen_message_tracker.sv =====
// Self-checking testbench for bloom_seen_message_tracker: a directed table, then random
// message and activate traffic under several skip settings, checked by a behavioral model.
// Depends on bsmt_pkg and the tracker RTL.
module tb_bloom_seen_message_tracker;
  import bsmt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 262144;
  localparam int unsigned PHASE_ITEMS    = 260;
  localparam int unsigned POOL_DEPTH     = 32;

  typedef struct {
    bsmt_in_t  item;
    bit        known;
    bsmt_out_t want;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  bsmt_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  bsmt_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_SKIP_UNSEEN;
  logic                 cfg_wdata_i = 1'b0;

  bloom_seen_message_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Tracker model state
  bit filter_bits [1 << FILTER_BITS_LOG2];
  bit menu_enabled   = 1'b1;
  bit menu_activated = 1'b0;
  bit filter_dirty   = 1'b0;
  bit cfg_skip_unseen    = 1'b0;
  bit cfg_stop_on_unseen = 1'b1;

  bsmt_out_t   menu_q [$];
  bsmt_in_t    recent_msgs [$];
  int unsigned mismatches  = 0;
  int unsigned rx_count    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_rx    = 1'b0;
  bit          quiet_tx    = 1'b0;
  bsmt_out_t   rx_want;

  dir_row_t dir_tab [18] = '{
    '{'{FUNC_ACTIVATE, 16'h0000, 16'h0000, 1'b0}, 1'b1, bsmt_out_t'(5'b01000)},
    '{'{FUNC_ACTIVATE, 16'h0000, 16'h0000, 1'b1}, 1'b1, bsmt_out_t'(5'b01110)},
    '{'{FUNC_ACTIVATE, 16'hffff, 16'hffff, 1'b1}, 1'b1, bsmt_out_t'(5'b01100)},
    '{'{FUNC_MESSAGE,  16'h0000, 16'h0000, 1'b1}, 1'b1, bsmt_out_t'(5'b10011)},
    '{'{FUNC_MESSAGE,  16'h0000, 16'h0000, 1'b0}, 1'b1, bsmt_out_t'(5'b01011)},
    '{'{FUNC_MESSAGE,  16'h0000, 16'h0000, 1'b0}, 1'b1, bsmt_out_t'(5'b01001)},
    '{'{FUNC_MESSAGE,  16'hffff, 16'hffff, 1'b1}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'hffff, 16'hffff, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'hffff, 16'h0000, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'h0000, 16'hffff, 1'b1}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_ACTIVATE, 16'h1234, 16'h4321, 1'b1}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'h8000, 16'h0001, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'h0001, 16'h8000, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'h5555, 16'haaaa, 1'b1}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'haaaa, 16'h5555, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_ACTIVATE, 16'h0000, 16'h0000, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'h0001, 16'h0001, 1'b0}, 1'b0, bsmt_out_t'(5'b00000)},
    '{'{FUNC_MESSAGE,  16'h0001, 16'h0001, 1'b1}, 1'b0, bsmt_out_t'(5'b00000)}
  };

  function automatic bsmt_out_t track_message(bsmt_in_t it);
    bsmt_out_t   res;
    logic [63:0] prod_page;
    logic [63:0] prod_addr;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] probe;
    bit          was_en;
    bit          was_act;
    res     = '0;
    was_en  = menu_enabled;
    was_act = menu_activated;
    if (it.func == FUNC_MESSAGE) begin
      prod_page = 64'(it.page) * 64'(KNUTH_MULT);
      prod_addr = 64'(it.addr) * 64'(KNUTH_MULT);
      h1 = prod_page[PAGE_SHIFT +: 32];
      h2 = prod_addr[ADDR_SHIFT +: 32];
      for (int i = 0; i < NUM_PROBES; i++) begin
        probe = h1 + 32'(i) * h2;
        if (!filter_bits[probe[FILTER_BITS_LOG2-1:0]]) begin
          res.unseen = 1'b1;
        end
        filter_bits[probe[FILTER_BITS_LOG2-1:0]] = 1'b1;
      end
      if (res.unseen) begin
        filter_dirty = 1'b1;
      end
      if (res.unseen && !cfg_skip_unseen) begin
        if (cfg_stop_on_unseen) begin
          menu_activated = 1'b0;
        end
        menu_enabled = 1'b0;
      end else begin
        menu_enabled = 1'b1;
      end
    end else begin
      menu_activated = it.activate_value;
    end
    res.skip_enabled   = menu_enabled;
    res.skip_activated = menu_activated;
    res.menu_changed   = (menu_enabled != was_en) || (menu_activated != was_act);
    res.filter_dirty   = filter_dirty;
    return res;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %b, got %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_count++;
      if (menu_q.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got %b", $time, out_data_o);
      end else begin
        rx_want = menu_q.pop_front();
        check_field("unseen", rx_want.unseen, out_data_o.unseen);
        check_field("skip_enabled", rx_want.skip_enabled, out_data_o.skip_enabled);
        check_field("skip_activated", rx_want.skip_activated, out_data_o.skip_activated);
        check_field("menu_changed", rx_want.menu_changed, out_data_o.menu_changed);
        check_field("filter_dirty", rx_want.filter_dirty, out_data_o.filter_dirty);
      end
      if (rx_count % 40 == 0) begin
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      stall_left = quiet_rx ? 0 : $urandom_range(0, 11);
      if (rx_count == 150) begin
        hold_left = 120;
      end
    end else if (out_valid_o && out_stall_i && stall_left != 0) begin
      stall_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
    end
    out_stall_i <= (stall_left != 0) || (hold_left != 0);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_bloom_seen_message_tracker: done, errors");
      $finish;
    end
  end

  task automatic offer(input bsmt_in_t item, output bsmt_out_t pred);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = track_message(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_SKIP_UNSEEN) begin
      cfg_skip_unseen = val;
    end else begin
      cfg_stop_on_unseen = val;
    end
  endtask

  task automatic set_skip_mode(input logic skip_unseen, input logic stop_on_unseen);
    write_reg(CFG_SKIP_UNSEEN, skip_unseen);
    write_reg(CFG_STOP_ON_UNSEEN, stop_on_unseen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (menu_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    bsmt_in_t    item;
    bsmt_out_t   pred;
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
      end
      item.page           = 16'($urandom);
      item.addr           = 16'($urandom);
      item.activate_value = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        item.func = FUNC_ACTIVATE;
      end else if (pick < 60 && recent_msgs.size() != 0) begin
        item      = recent_msgs[$urandom_range(0, recent_msgs.size() - 1)];
        item.activate_value = 1'($urandom);
      end else begin
        item.func = FUNC_MESSAGE;
        if ($urandom_range(0, 3) == 0) begin
          item.page = 16'($urandom_range(0, 15));
        end
        recent_msgs.push_back(item);
        if (recent_msgs.size() > POOL_DEPTH) begin
          void'(recent_msgs.pop_front());
        end
      end
      offer(item, pred);
      menu_q.push_back(pred);
    end
  endtask

  initial begin
    bsmt_out_t pred;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_skip_mode(1'b0, 1'b1);

    foreach (dir_tab[r]) begin
      offer(dir_tab[r].item, pred);
      menu_q.push_back(dir_tab[r].known ? dir_tab[r].want : pred);
    end
    drain();

    set_skip_mode(1'b1, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    set_skip_mode(1'b0, 1'b0);
    run_random(PHASE_ITEMS);
    drain();
    set_skip_mode(1'b1, 1'b1);
    run_random(PHASE_ITEMS);
    drain();
    set_skip_mode(1'b0, 1'b1);
    run_random(PHASE_ITEMS);
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && menu_q.size() == 0) begin
      $display("tb_bloom_seen_message_tracker: done, clean");
    end else begin
      $display("tb_bloom_seen_message_tracker: done, errors");
    end
    $finish;
  end

endmodule
